>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent checked in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/ljtw_pkg.sv
// ----------------------------------------------------------------------------
// ljtw_pkg
// Types, field widths and fixed-point constants of the leading-jet tower
// window filter.
// ----------------------------------------------------------------------------
package ljtw_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int ENERGY_W = 18;
    localparam int ETA_W    = 20;
    localparam int PHI_W    = 19;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;

    // Stream packing
    localparam int FIELD_BITS = 2 * ENERGY_W + 3 * ETA_W + 3 * PHI_W;
    localparam int TDATA_W    = ((FIELD_BITS + 7) / 8) * 8;
    localparam int PAD_W      = TDATA_W - FIELD_BITS;
    localparam int M_TUSER_W  = 2;

    // Configuration reset values (1/16 GeV)
    localparam logic [CFG_W-1:0] PT_MIN_RST   = 18'd3200;
    localparam logic [CFG_W-1:0] PT_MAX_RST   = 18'd4800;
    localparam logic [CFG_W-1:0] MASS_MIN_RST = 18'd1040;
    localparam logic [CFG_W-1:0] MASS_MAX_RST = 18'd1520;

    // Binning: eta step 0.0714, phi step pi/44, both 4679 in 2^-16 units
    localparam int ETA_STEP      = 4679;
    localparam int PHI_STEP      = 4679;
    localparam int ETA_LOW       = -159095;
    localparam int BINS_DOWN     = 12;
    localparam int BINS_UP       = 13;
    localparam int PHI_WRAP      = 88;
    localparam int PHI_WRAP_LOW  = -32;
    localparam int PHI_WRAP_HIGH = 31;

    localparam int ETA_DN_OFS = BINS_DOWN * ETA_STEP;
    localparam int ETA_UP_OFS = BINS_UP * ETA_STEP;
    localparam int PHI_DN_OFS = BINS_DOWN * PHI_STEP;
    localparam int PHI_UP_OFS = BINS_UP * PHI_STEP;
    localparam int PHI_WRAP_OFS = PHI_WRAP * PHI_STEP;

    // Reciprocal divide by 4679: floor(2^32 / 4679), estimate low by at most one
    localparam int MAG_W   = 20;
    localparam int RECIP_W = 20;
    localparam int RECIP_SHIFT = 32;
    localparam logic [RECIP_W-1:0] STEP_RECIP = 20'd917924;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int QUO_W   = PROD_W - RECIP_SHIFT;
    localparam int REM_W   = 14;
    localparam int DIFF_W  = MAG_W + 1;
    localparam int THR_W   = 23;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [OP_W-1:0] {
        OP_JET   = 2'd0,
        OP_TOWER = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PT_MIN   = 2'd0,
        REG_PT_MAX   = 2'd1,
        REG_MASS_MIN = 2'd2,
        REG_MASS_MAX = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_JET,
        KIND_TOWER,
        KIND_SUMMARY
    } item_kind_t;

    // Input tdata, first field in the low bits
    typedef struct packed {
        logic [PAD_W-1:0]        pad;
        logic signed [PHI_W-1:0] phi_hi;
        logic signed [PHI_W-1:0] phi_lo;
        logic signed [ETA_W-1:0] eta_hi;
        logic signed [ETA_W-1:0] eta_lo;
        logic signed [PHI_W-1:0] phi_center;
        logic signed [ETA_W-1:0] eta_center;
        logic [ENERGY_W-1:0]     jet_mass_in;
        logic [ENERGY_W-1:0]     energy_value;
    } in_data_t;

    // Output tdata, first field in the low bits
    typedef struct packed {
        logic [PAD_W-1:0]        pad;
        logic signed [PHI_W-1:0] out_phi_hi;
        logic signed [PHI_W-1:0] out_phi_lo;
        logic signed [ETA_W-1:0] out_eta_hi;
        logic signed [ETA_W-1:0] out_eta_lo;
        logic signed [PHI_W-1:0] out_phi;
        logic signed [ETA_W-1:0] out_eta;
        logic [ENERGY_W-1:0]     out_mass;
        logic [ENERGY_W-1:0]     out_energy;
    } out_data_t;

    typedef struct packed {
        logic jet_found;
        logic out_kind;
    } out_user_t;

    // Work item handed from the front to the back
    typedef struct packed {
        item_kind_t              kind;
        logic                    found;
        logic [ENERGY_W-1:0]     energy;
        logic [ENERGY_W-1:0]     mass;
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
        logic signed [ETA_W-1:0] eta_lo;
        logic signed [ETA_W-1:0] eta_hi;
        logic signed [PHI_W-1:0] phi_lo;
        logic signed [PHI_W-1:0] phi_hi;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> hw/rtl/ljtw_front.sv
// ----------------------------------------------------------------------------
// ljtw_front
// Accepts stream items, applies the jet windows, keeps the leading jet of
// the event and forwards jet updates, towers and summaries to the queue.
// ----------------------------------------------------------------------------
module ljtw_front
    import ljtw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  q_stat_t              q_stat,
    output logic                 push,
    output item_t                push_item
);

    logic [CFG_W-1:0] pt_min_reg, pt_max_reg, mass_min_reg, mass_max_reg;

    logic [ENERGY_W-1:0]     best_pt_reg, best_pt_next;
    logic [ENERGY_W-1:0]     best_mass_reg, best_mass_next;
    logic signed [ETA_W-1:0] best_eta_reg, best_eta_next;
    logic signed [PHI_W-1:0] best_phi_reg, best_phi_next;
    logic                    have_jet_reg, have_jet_next;

    in_data_t in_data;
    op_t      op;
    logic     accept;
    logic     jet_take;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_min_reg   <= PT_MIN_RST;
            pt_max_reg   <= PT_MAX_RST;
            mass_min_reg <= MASS_MIN_RST;
            mass_max_reg <= MASS_MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PT_MIN:   pt_min_reg   <= cfg_wdata;
                REG_PT_MAX:   pt_max_reg   <= cfg_wdata;
                REG_MASS_MIN: mass_min_reg <= cfg_wdata;
                REG_MASS_MAX: mass_max_reg <= cfg_wdata;
            endcase
        end
    end

    // Leading-jet state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_pt_reg   <= '0;
            best_mass_reg <= '0;
            best_eta_reg  <= '0;
            best_phi_reg  <= '0;
            have_jet_reg  <= 1'b0;
        end else begin
            best_pt_reg   <= best_pt_next;
            best_mass_reg <= best_mass_next;
            best_eta_reg  <= best_eta_next;
            best_phi_reg  <= best_phi_next;
            have_jet_reg  <= have_jet_next;
        end
    end

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    // Classify the item, update the selection, build the queue entry
    always_comb begin
        in_data = in_data_t'(s_tdata);
        op      = op_t'(s_tuser);

        // windows inclusive, strict gain over the current leader
        jet_take = (in_data.energy_value >= pt_min_reg)
                && (in_data.energy_value <= pt_max_reg)
                && (in_data.jet_mass_in >= mass_min_reg)
                && (in_data.jet_mass_in <= mass_max_reg)
                && (in_data.energy_value > best_pt_reg);

        best_pt_next   = best_pt_reg;
        best_mass_next = best_mass_reg;
        best_eta_next  = best_eta_reg;
        best_phi_next  = best_phi_reg;
        have_jet_next  = have_jet_reg;

        push             = 1'b0;
        push_item        = '0;
        push_item.kind   = KIND_JET;
        push_item.eta    = in_data.eta_center;
        push_item.phi    = in_data.phi_center;

        if (accept) begin
            unique case (op)
                OP_JET: begin
                    if (jet_take) begin
                        best_pt_next   = in_data.energy_value;
                        best_mass_next = in_data.jet_mass_in;
                        best_eta_next  = in_data.eta_center;
                        best_phi_next  = in_data.phi_center;
                        have_jet_next  = 1'b1;
                        // back recomputes the tower windows from this jet
                        push           = 1'b1;
                        push_item.kind = KIND_JET;
                    end
                end
                OP_TOWER: begin
                    if (have_jet_reg) begin
                        push             = 1'b1;
                        push_item.kind   = KIND_TOWER;
                        push_item.found  = 1'b1;
                        push_item.energy = in_data.energy_value;
                        push_item.eta_lo = in_data.eta_lo;
                        push_item.eta_hi = in_data.eta_hi;
                        push_item.phi_lo = in_data.phi_lo;
                        push_item.phi_hi = in_data.phi_hi;
                    end
                end
                OP_END: begin
                    push             = 1'b1;
                    push_item.kind   = KIND_SUMMARY;
                    push_item.found  = have_jet_reg;
                    push_item.energy = best_pt_reg;
                    push_item.mass   = best_mass_reg;
                    push_item.eta    = best_eta_reg;
                    push_item.phi    = best_phi_reg;
                    best_pt_next     = '0;
                    best_mass_next   = '0;
                    best_eta_next    = '0;
                    best_phi_next    = '0;
                    have_jet_next    = 1'b0;
                end
                OP_NONE: begin
                    // unused code: dropped
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/ljtw_queue.sv
// ----------------------------------------------------------------------------
// ljtw_queue
// Short register FIFO of work items between the front and the back.
// ----------------------------------------------------------------------------
module ljtw_queue
    import ljtw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  item_t   wr_item,
    input  logic    rd_en,
    output item_t   rd_item,
    output q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_item    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

>>> hw/rtl/ljtw_back.sv
// ----------------------------------------------------------------------------
// ljtw_back
// Turns leading-jet updates into tower windows (reciprocal divide by the
// bin step over three stages), filters towers against the current window
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module ljtw_back
    import ljtw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  q_stat_t                q_stat,
    input  item_t                  rd_item,
    output logic                   rd_en,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,
    output logic [M_TUSER_W-1:0]   m_tuser
);

    localparam logic [REM_W-1:0] STEP_REM = REM_W'(ETA_STEP);

    // pipeline control
    logic advance;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;

    // stage 1: magnitudes and signs
    item_t              s1_item_reg;
    logic [MAG_W-1:0]   s1_mag_e_reg, s1_mag_p_reg;
    logic               s1_neg_e_reg, s1_neg_p_reg;
    // stage 2: reciprocal products
    item_t              s2_item_reg;
    logic [MAG_W-1:0]   s2_mag_e_reg, s2_mag_p_reg;
    logic [PROD_W-1:0]  s2_prod_e_reg, s2_prod_p_reg;
    logic               s2_neg_e_reg, s2_neg_p_reg;
    // stage 3: raw remainders
    item_t              s3_item_reg;
    logic [REM_W-1:0]   s3_rem_e_reg, s3_rem_p_reg;
    logic [QUO_W-1:0]   s3_quo_p_reg;
    logic               s3_neg_e_reg, s3_neg_p_reg;

    // tower window of the current leading jet
    logic signed [THR_W-1:0] thr_elo_reg, thr_ehi_reg, thr_plo_reg, thr_phi_reg;
    logic                    thr_wrap_reg;

    out_data_t out_data_reg, out_data_next;
    out_user_t out_user_reg, out_user_next;

    logic signed [DIFF_W-1:0] d_eta, phi_x;
    logic [MAG_W-1:0]         mag_e, mag_p;
    logic [QUO_W-1:0]         quo_e_est, quo_p_est;
    logic [DIFF_W-1:0]        diff_e, diff_p;

    logic [REM_W-1:0]        rem_e, rem_p;
    logic [QUO_W-1:0]        quo_p;
    logic signed [THR_W-1:0] rem_e_x, rem_p_x, eta_x, phi_cx;
    logic signed [THR_W-1:0] base_e, base_p;
    logic signed [THR_W-1:0] elo_next, ehi_next, plo_next, phi_next;
    logic                    wrap_low, wrap_high;
    logic signed [THR_W-1:0] tw_elo, tw_plo;
    logic                    eta_ok, phi_ok, tower_pass, s3_emits;

    // Whole back pipeline moves when the output register is free
    assign advance  = !out_valid_reg || m_tready;
    assign rd_en    = advance && !q_stat.empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);
    assign m_tuser  = M_TUSER_W'(out_user_reg);

    // Stage 1 inputs: distance from the eta grid edge, phi magnitude
    always_comb begin
        d_eta = DIFF_W'(rd_item.eta) - DIFF_W'(ETA_LOW);
        phi_x = DIFF_W'(rd_item.phi);
        mag_e = d_eta[DIFF_W-1] ? MAG_W'(-d_eta) : d_eta[MAG_W-1:0];
        mag_p = phi_x[DIFF_W-1] ? MAG_W'(-phi_x) : phi_x[MAG_W-1:0];
    end

    // Stage 3 inputs: remainder before the final correction
    always_comb begin
        quo_e_est = s2_prod_e_reg[PROD_W-1:RECIP_SHIFT];
        quo_p_est = s2_prod_p_reg[PROD_W-1:RECIP_SHIFT];
        diff_e = {1'b0, s2_mag_e_reg} - DIFF_W'(quo_e_est * ETA_STEP);
        diff_p = {1'b0, s2_mag_p_reg} - DIFF_W'(quo_p_est * PHI_STEP);
    end

    // Window of a new leading jet; truncation toward zero means
    // index * step = value - signed remainder
    always_comb begin
        rem_e = (s3_rem_e_reg >= STEP_REM) ? s3_rem_e_reg - STEP_REM : s3_rem_e_reg;
        rem_p = (s3_rem_p_reg >= STEP_REM) ? s3_rem_p_reg - STEP_REM : s3_rem_p_reg;
        quo_p = s3_quo_p_reg + QUO_W'(s3_rem_p_reg >= STEP_REM);

        rem_e_x = THR_W'(rem_e);
        rem_p_x = THR_W'(rem_p);
        eta_x   = THR_W'(s3_item_reg.eta);
        phi_cx  = THR_W'(s3_item_reg.phi);

        base_e = s3_neg_e_reg ? eta_x + rem_e_x : eta_x - rem_e_x;
        base_p = s3_neg_p_reg ? phi_cx + rem_p_x : phi_cx - rem_p_x;

        elo_next = base_e - THR_W'(ETA_DN_OFS);
        ehi_next = base_e + THR_W'(ETA_UP_OFS);
        plo_next = base_p - THR_W'(PHI_DN_OFS);
        phi_next = base_p + THR_W'(PHI_UP_OFS);

        // phi band across +-pi
        wrap_low  = s3_neg_p_reg && (quo_p > QUO_W'(-PHI_WRAP_LOW));
        wrap_high = !s3_neg_p_reg && (quo_p > QUO_W'(PHI_WRAP_HIGH));
        if (wrap_low) begin
            plo_next = plo_next + THR_W'(PHI_WRAP_OFS);
        end else if (wrap_high) begin
            phi_next = phi_next - THR_W'(PHI_WRAP_OFS);
        end
    end

    // Tower filter against the stored window
    always_comb begin
        tw_elo = THR_W'(s3_item_reg.eta_lo);
        tw_plo = THR_W'(s3_item_reg.phi_lo);
        eta_ok = (tw_elo > thr_elo_reg) && (tw_elo < thr_ehi_reg);
        if (thr_wrap_reg) begin
            phi_ok = (tw_plo >= thr_plo_reg) || (tw_plo <= thr_phi_reg);
        end else begin
            phi_ok = (tw_plo >= thr_plo_reg) && (tw_plo <= thr_phi_reg);
        end
        tower_pass = eta_ok && phi_ok;

        unique case (s3_item_reg.kind)
            KIND_TOWER:   s3_emits = tower_pass;
            KIND_SUMMARY: s3_emits = 1'b1;
            default:      s3_emits = 1'b0;
        endcase

        out_data_next            = '0;
        out_data_next.out_energy = s3_item_reg.energy;
        out_data_next.out_mass   = s3_item_reg.mass;
        out_data_next.out_eta    = s3_item_reg.eta;
        out_data_next.out_phi    = s3_item_reg.phi;
        out_data_next.out_eta_lo = s3_item_reg.eta_lo;
        out_data_next.out_eta_hi = s3_item_reg.eta_hi;
        out_data_next.out_phi_lo = s3_item_reg.phi_lo;
        out_data_next.out_phi_hi = s3_item_reg.phi_hi;
        out_user_next.out_kind   = (s3_item_reg.kind == KIND_SUMMARY);
        out_user_next.jet_found  = s3_item_reg.found;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= !q_stat.empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg && s3_emits;
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_item_reg  <= rd_item;
            s1_mag_e_reg <= mag_e;
            s1_mag_p_reg <= mag_p;
            s1_neg_e_reg <= d_eta[DIFF_W-1];
            s1_neg_p_reg <= phi_x[DIFF_W-1];

            s2_item_reg   <= s1_item_reg;
            s2_mag_e_reg  <= s1_mag_e_reg;
            s2_mag_p_reg  <= s1_mag_p_reg;
            s2_prod_e_reg <= PROD_W'(s1_mag_e_reg) * PROD_W'(STEP_RECIP);
            s2_prod_p_reg <= PROD_W'(s1_mag_p_reg) * PROD_W'(STEP_RECIP);
            s2_neg_e_reg  <= s1_neg_e_reg;
            s2_neg_p_reg  <= s1_neg_p_reg;

            s3_item_reg  <= s2_item_reg;
            s3_rem_e_reg <= diff_e[REM_W-1:0];
            s3_rem_p_reg <= diff_p[REM_W-1:0];
            s3_quo_p_reg <= quo_p_est;
            s3_neg_e_reg <= s2_neg_e_reg;
            s3_neg_p_reg <= s2_neg_p_reg;

            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    // Window registers follow jet updates in stream order
    always_ff @(posedge aclk) begin
        if (advance && s3_valid_reg && (s3_item_reg.kind == KIND_JET)) begin
            thr_elo_reg  <= elo_next;
            thr_ehi_reg  <= ehi_next;
            thr_plo_reg  <= plo_next;
            thr_phi_reg  <= phi_next;
            thr_wrap_reg <= wrap_low || wrap_high;
        end
    end

endmodule

>>> hw/rtl/leading_jet_tower_window_filter.sv
// ----------------------------------------------------------------------------
// leading_jet_tower_window_filter
// Per-event leading-jet selection and tower window filter.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser carries the op (jet, tower, end of event), tdata
//   the energy, mass, center and edge fields. Each event sends its jets,
//   then its towers, then one end marker.
//   Output stream m_*: one transfer per tower inside the window of the
//   leading jet, and one summary transfer per end marker.
//   Configuration: cfg_we/cfg_index/cfg_wdata set the pt and mass windows;
//   write only while the block is empty.
//   Throughput: one input item per cycle, sustained while m_tready is high.
//   Path: a result passes the queue, the three back stages and the output
//   register before it is valid on m_tvalid. The window
//   of a new leading jet takes three back stages and is ready in order
//   for the tower that follows it.
//   Stall: while a result waits on m_tready the back holds; the queue of
//   QUEUE_DEPTH entries absorbs input and s_tready drops once it is full.
//   Reset: windows return to their defaults, the selection is cleared, the
//   queue and the pipeline are emptied; no clearing pass is needed.
// ----------------------------------------------------------------------------
module leading_jet_tower_window_filter
    import ljtw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // energy_value, jet_mass_in, eta_center, phi_center, eta_lo, eta_hi,
    // phi_lo, phi_hi, zero pad
    input  logic [TDATA_W-1:0]   s_tdata,
    // op
    input  logic [OP_W-1:0]      s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_energy, out_mass, out_eta, out_phi, out_eta_lo, out_eta_hi,
    // out_phi_lo, out_phi_hi, zero pad
    output logic [TDATA_W-1:0]   m_tdata,
    // out_kind, jet_found
    output logic [M_TUSER_W-1:0] m_tuser
);

    q_stat_t q_stat;
    logic    push, pop;
    item_t   push_item, head_item;

    ljtw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    ljtw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_item (push_item),
        .rd_en   (pop),
        .rd_item (head_item),
        .stat    (q_stat)
    );

    ljtw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .rd_item  (head_item),
        .rd_en    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> hw/rtl/ljtw_checker.sv
// ----------------------------------------------------------------------------
// ljtw_checker
// Port-level checks on the result stream of the window filter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ljtw_checker
    import ljtw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [TDATA_W-1:0]   m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // Stalled transfer stays offered and unchanged
    `ASSERT_NEXT(a_stall_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_stall_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // Towers only leave when a jet was selected
    `ASSERT_IMPL(a_tower_has_jet, aclk, aresetn, m_tvalid && !m_tuser[0], m_tuser[1])

    // Summary without a jet carries zero pt and mass
    `ASSERT_IMPL(a_empty_summary, aclk, aresetn, m_tvalid && m_tuser[0] && !m_tuser[1], m_tdata[35:0] == 36'd0)

    // Summary carries no tower edges
    `ASSERT_IMPL(a_summary_edges, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[159:75] == 85'd0)

endmodule

bind leading_jet_tower_window_filter ljtw_checker u_ljtw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/leading_jet_tower_window_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leading_jet_tower_window_filter_tb
// Self-checking bench for the leading-jet tower window filter. A queue of
// events (jets, towers, end markers) feeds the input stream; a model
// of the jet selection and the eta/phi tower window predicts every tower
// and summary transfer, and the monitor compares them field by field. The
// run steps through several pt/mass window settings and idle patterns.
// ----------------------------------------------------------------------------
module leading_jet_tower_window_filter_tb;
    import ljtw_pkg::*;

    // Binning of the window, kept apart from the package on purpose
    localparam longint BIN_STEP      = 4679;
    localparam longint ETA_ORIGIN    = -159095;
    localparam longint WIN_DOWN      = 12;
    localparam longint WIN_UP        = 13;
    localparam longint WRAP_BINS     = 88;
    localparam longint WRAP_LOW_BIN  = -32;
    localparam longint WRAP_HIGH_BIN = 31;
    localparam int     ETA_SPAN      = 327680;
    localparam int     PHI_SPAN      = 205887;
    localparam int     NUM_PHASES    = 8;
    localparam int     PHASE_ITEMS   = 112;
    localparam int     SETTLE_CYCLES = 12;

    typedef struct {
        op_t                     op;
        logic [ENERGY_W-1:0]     energy;
        logic [ENERGY_W-1:0]     mass;
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
        logic signed [ETA_W-1:0] eta_lo;
        logic signed [ETA_W-1:0] eta_hi;
        logic signed [PHI_W-1:0] phi_lo;
        logic signed [PHI_W-1:0] phi_hi;
    } calo_item_t;

    typedef struct {
        logic                kind;
        logic                found;
        logic [ENERGY_W-1:0] energy;
        logic [ENERGY_W-1:0] mass;
        logic [ETA_W-1:0]    eta;
        logic [PHI_W-1:0]    phi;
        logic [ETA_W-1:0]    eta_lo;
        logic [ETA_W-1:0]    eta_hi;
        logic [PHI_W-1:0]    phi_lo;
        logic [PHI_W-1:0]    phi_hi;
    } filt_result_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    leading_jet_tower_window_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Windows and event selection as the bench sees them
    logic [CFG_W-1:0]    win_pt_lo, win_pt_hi, win_mass_lo, win_mass_hi;
    logic [ENERGY_W-1:0] sel_pt, sel_mass;
    longint              sel_eta, sel_phi;
    logic                sel_valid;

    calo_item_t   outgoing_items[$];
    filt_result_t due_results[$];
    calo_item_t   in_flight;

    int gap_pct   = 0;
    int stall_pct = 0;
    int items_queued, items_taken;
    int towers_seen, summaries_seen, summaries_with_jet;
    int err_count;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic note_failure(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic bit tower_in_window(longint elo, longint plo);
        longint ebin, pbin, dn_bin, up_bin, lo_edge, hi_edge;
        ebin   = (sel_eta - ETA_ORIGIN) / BIN_STEP;   // truncates toward zero
        pbin   = sel_phi / BIN_STEP;
        dn_bin = pbin - WIN_DOWN;
        up_bin = pbin + WIN_UP;
        // eta: strictly inside the band
        if (elo <= ETA_ORIGIN + (ebin - WIN_DOWN) * BIN_STEP) return 1'b0;
        if (elo >= ETA_ORIGIN + (ebin + WIN_UP) * BIN_STEP) return 1'b0;
        // phi: band wraps across +-pi near the ends
        if (pbin < WRAP_LOW_BIN)
            dn_bin = WRAP_BINS + pbin - WIN_DOWN;
        else if (pbin > WRAP_HIGH_BIN)
            up_bin = pbin + WIN_UP - WRAP_BINS;
        lo_edge = dn_bin * BIN_STEP;
        hi_edge = up_bin * BIN_STEP;
        if (hi_edge > lo_edge && (plo < lo_edge || plo > hi_edge)) return 1'b0;
        if (hi_edge < lo_edge && plo < lo_edge && plo > hi_edge) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_selection();
        sel_pt    = '0;
        sel_mass  = '0;
        sel_eta   = 0;
        sel_phi   = 0;
        sel_valid = 1'b0;
    endfunction

    // Update the selection with one accepted item, queue its result if any
    function automatic void track_event(calo_item_t it);
        filt_result_t r;
        r = '{default: '0};
        case (it.op)
            OP_JET: begin
                if (it.energy >= win_pt_lo && it.energy <= win_pt_hi &&
                    it.mass >= win_mass_lo && it.mass <= win_mass_hi &&
                    it.energy > sel_pt) begin
                    sel_pt    = it.energy;
                    sel_mass  = it.mass;
                    sel_eta   = longint'(it.eta);
                    sel_phi   = longint'(it.phi);
                    sel_valid = 1'b1;
                end
            end
            OP_TOWER: begin
                if (sel_valid &&
                    tower_in_window(longint'(it.eta_lo), longint'(it.phi_lo))) begin
                    r.found  = 1'b1;
                    r.energy = it.energy;
                    r.eta    = it.eta;
                    r.phi    = it.phi;
                    r.eta_lo = it.eta_lo;
                    r.eta_hi = it.eta_hi;
                    r.phi_lo = it.phi_lo;
                    r.phi_hi = it.phi_hi;
                    due_results.insert(due_results.size(), r);
                end
            end
            OP_END: begin
                r.kind   = 1'b1;
                r.found  = sel_valid;
                r.energy = sel_pt;
                r.mass   = sel_mass;
                r.eta    = sel_eta[ETA_W-1:0];
                r.phi    = sel_phi[PHI_W-1:0];
                due_results.insert(due_results.size(), r);
                clear_selection();
            end
            default: ;  // unused op: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: one transfer per handshake, random gaps between items
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive
        in_data_t d;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_event(in_flight);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (outgoing_items.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
                    in_flight      = outgoing_items.pop_front();
                    d              = '0;
                    d.energy_value = in_flight.energy;
                    d.jet_mass_in  = in_flight.mass;
                    d.eta_center   = in_flight.eta;
                    d.phi_center   = in_flight.phi;
                    d.eta_lo       = in_flight.eta_lo;
                    d.eta_hi       = in_flight.eta_hi;
                    d.phi_lo       = in_flight.phi_lo;
                    d.phi_hi       = in_flight.phi_hi;
                    s_tvalid <= 1'b1;
                    s_tdata  <= d;
                    s_tuser  <= in_flight.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected %h got %h", name, want, got));
    endtask

    always @(posedge aclk) begin : watch
        out_data_t    od;
        out_user_t    ou;
        filt_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                od = m_tdata;
                ou = m_tuser;
                if (ou.out_kind) begin
                    summaries_seen++;
                    if (ou.jet_found) summaries_with_jet++;
                end else begin
                    towers_seen++;
                end
                if (due_results.size() == 0) begin
                    note_failure($sformatf("unexpected result, kind %0d energy %h",
                                           ou.out_kind, od.out_energy));
                end else begin
                    want = due_results.pop_front();
                    check_field("out_kind",   20'(want.kind),   20'(ou.out_kind));
                    check_field("jet_found",  20'(want.found),  20'(ou.jet_found));
                    check_field("out_energy", 20'(want.energy), 20'(od.out_energy));
                    check_field("out_mass",   20'(want.mass),   20'(od.out_mass));
                    check_field("out_eta",    want.eta,    $unsigned(od.out_eta));
                    check_field("out_phi",    20'(want.phi),
                                20'($unsigned(od.out_phi)));
                    check_field("out_eta_lo", want.eta_lo, $unsigned(od.out_eta_lo));
                    check_field("out_eta_hi", want.eta_hi, $unsigned(od.out_eta_hi));
                    check_field("out_phi_lo", 20'(want.phi_lo),
                                20'($unsigned(od.out_phi_lo)));
                    check_field("out_phi_hi", 20'(want.phi_hi),
                                20'($unsigned(od.out_phi_hi)));
                end
            end
            m_tready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rand_span(int span);
        return int'($urandom_range(2 * span, 0)) - span;
    endfunction

    function automatic int clip_eta(int v);
        if (v > ETA_SPAN) return ETA_SPAN;
        if (v < -ETA_SPAN) return -ETA_SPAN;
        return v;
    endfunction

    function automatic int wrap_phi(int v);
        if (v > PHI_SPAN) return v - 2 * PHI_SPAN;
        if (v < -PHI_SPAN) return v + 2 * PHI_SPAN;
        return v;
    endfunction

    // Pt or mass aimed at a window: mostly inside, some edges and misses
    function automatic logic [CFG_W-1:0] window_value(logic [CFG_W-1:0] lo,
                                                      logic [CFG_W-1:0] hi);
        case ($urandom_range(11, 0))
            0: return lo - 1'b1;
            1: return hi + 1'b1;
            2: return CFG_W'($urandom_range(262143, 0));
            3: return lo;
            4: return hi;
            5: return '0;
            default: begin
                if (lo <= hi) return CFG_W'($urandom_range(hi, lo));
                return CFG_W'($urandom_range(262143, 0));
            end
        endcase
    endfunction

    function automatic calo_item_t random_item(op_t op);
        calo_item_t it;
        it.op     = op;
        it.energy = ENERGY_W'($urandom_range(262143, 0));
        it.mass   = ENERGY_W'($urandom_range(262143, 0));
        if ($urandom_range(19, 0) == 0) begin
            // full-width values, beyond the physical range
            it.eta    = ETA_W'($urandom);
            it.phi    = PHI_W'($urandom);
            it.eta_lo = ETA_W'($urandom);
            it.eta_hi = ETA_W'($urandom);
            it.phi_lo = PHI_W'($urandom);
            it.phi_hi = PHI_W'($urandom);
        end else begin
            it.eta    = ETA_W'(rand_span(ETA_SPAN));
            it.phi    = PHI_W'(rand_span(PHI_SPAN));
            it.eta_lo = ETA_W'(rand_span(ETA_SPAN));
            it.eta_hi = ETA_W'(rand_span(ETA_SPAN));
            it.phi_lo = PHI_W'(rand_span(PHI_SPAN));
            it.phi_hi = PHI_W'(rand_span(PHI_SPAN));
        end
        return it;
    endfunction

    task automatic add_item(calo_item_t it);
        outgoing_items.insert(outgoing_items.size(), it);
        items_queued++;
    endtask

    task automatic add_fields(op_t op, int e, int m, int eta, int phi,
                              int elo, int ehi, int plo, int phi_hi);
        calo_item_t it;
        it.op     = op;
        it.energy = ENERGY_W'(e);
        it.mass   = ENERGY_W'(m);
        it.eta    = ETA_W'(eta);
        it.phi    = PHI_W'(phi);
        it.eta_lo = ETA_W'(elo);
        it.eta_hi = ETA_W'(ehi);
        it.phi_lo = PHI_W'(plo);
        it.phi_hi = PHI_W'(phi_hi);
        add_item(it);
    endtask

    // One event: jets, towers around the last jet, usually an end marker
    task automatic queue_event();
        int         n_jets, n_towers, k, aim_eta, aim_phi;
        calo_item_t it;
        n_jets   = $urandom_range(4, 0);
        n_towers = $urandom_range(8, 0);
        aim_eta  = rand_span(ETA_SPAN);
        aim_phi  = rand_span(PHI_SPAN);
        for (k = 0; k < n_jets; k++) begin
            it        = random_item(OP_JET);
            it.energy = window_value(win_pt_lo, win_pt_hi);
            it.mass   = window_value(win_mass_lo, win_mass_hi);
            aim_eta   = int'(it.eta);
            aim_phi   = int'(it.phi);
            add_item(it);
        end
        for (k = 0; k < n_towers; k++) begin
            it        = random_item(OP_TOWER);
            it.eta_lo = ETA_W'(clip_eta(aim_eta + rand_span(int'(16 * BIN_STEP))));
            it.phi_lo = PHI_W'(wrap_phi(aim_phi + rand_span(int'(16 * BIN_STEP))));
            add_item(it);
            // late jet after some towers
            if ($urandom_range(14, 0) == 0) begin
                it        = random_item(OP_JET);
                it.energy = window_value(win_pt_lo, win_pt_hi);
                it.mass   = window_value(win_mass_lo, win_mass_hi);
                add_item(it);
            end
        end
        if ($urandom_range(19, 0) != 0)
            add_fields(OP_END, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // Wait until every item is taken and every result is back, then settle
    task automatic drain();
        int guard;
        guard = 0;
        while ((items_taken != items_queued || due_results.size() != 0) && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        if (items_taken != items_queued) begin
            note_failure($sformatf("%0d input items never accepted",
                                   items_queued - items_taken));
        end
        if (due_results.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived",
                                   due_results.size()));
            due_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        case (r)
            REG_PT_MIN:   win_pt_lo   = v;
            REG_PT_MAX:   win_pt_hi   = v;
            REG_MASS_MIN: win_mass_lo = v;
            REG_MASS_MAX: win_mass_hi = v;
            default: ;
        endcase
    endtask

    task automatic set_windows(logic [CFG_W-1:0] pt_lo, logic [CFG_W-1:0] pt_hi,
                               logic [CFG_W-1:0] m_lo, logic [CFG_W-1:0] m_hi);
        write_reg(REG_PT_MIN, pt_lo);
        write_reg(REG_PT_MAX, pt_hi);
        write_reg(REG_MASS_MIN, m_lo);
        write_reg(REG_MASS_MAX, m_hi);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] rand_low();
        return CFG_W'($urandom_range(200000, 0));
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int               ph, start;
        logic [CFG_W-1:0] lo_a, lo_b;
        win_pt_lo   = 18'd3200;
        win_pt_hi   = 18'd4800;
        win_mass_lo = 18'd1040;
        win_mass_hi = 18'd1520;
        clear_selection();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed events under the reset windows
        add_fields(OP_TOWER, 100, 0, 0, 0, 0, 100, 0, 100);        // no jet yet
        add_fields(OP_END, 0, 0, 0, 0, 0, 0, 0, 0);                // empty summary
        add_fields(OP_JET, 4000, 1200, 3000, -2000, 0, 0, 0, 0);
        add_fields(OP_JET, 3199, 1200, 0, 0, 0, 0, 0, 0);          // pt below
        add_fields(OP_JET, 4801, 1200, 0, 0, 0, 0, 0, 0);          // pt above
        add_fields(OP_JET, 4800, 1039, 0, 0, 0, 0, 0, 0);          // mass below
        add_fields(OP_JET, 4800, 1521, 0, 0, 0, 0, 0, 0);          // mass above
        add_fields(OP_JET, 4800, 1520, 0, 0, 0, 0, 0, 0);          // upper edges, kept
        add_fields(OP_JET, 4800, 1040, 7000, 7000, 0, 0, 0, 0);    // tie, first stays
        add_fields(OP_JET, 3200, 1040, 0, 0, 0, 0, 0, 0);          // lower edges
        // eta band of a jet at zero: (-56157, 60818) open
        add_fields(OP_TOWER, 10, 0, 0, 0, -56157, 0, 0, 0);
        add_fields(OP_TOWER, 262143, 0, ETA_SPAN, PHI_SPAN, -56156, ETA_SPAN, 0, PHI_SPAN);
        add_fields(OP_TOWER, 0, 0, -ETA_SPAN, -PHI_SPAN, 60817, -ETA_SPAN, -56148,
                   -PHI_SPAN);
        add_fields(OP_TOWER, 11, 0, 0, 0, 60818, 0, 0, 0);
        // phi band [-56148, 60827] closed
        add_fields(OP_TOWER, 12, 0, 0, 0, 0, 0, -56149, 0);
        add_fields(OP_TOWER, 13, 0, 0, 0, 0, 0, 60827, 0);
        add_fields(OP_TOWER, 14, 0, 0, 0, 0, 0, 60828, 0);
        add_fields(OP_NONE, 4500, 1300, 1, 1, 0, 0, 0, 0);         // ignored op
        add_fields(OP_END, 0, 0, 0, 0, 0, 0, 0, 0);
        // jet near -pi, eta beyond the physical range: phi band wraps
        add_fields(OP_JET, 4500, 1300, 524287, -PHI_SPAN, 0, 0, 0, 0);
        add_fields(OP_TOWER, 20, 0, 0, 0, 500000, 0, 200000, 0);
        add_fields(OP_TOWER, 21, 0, 0, 0, 500000, 0, 0, 0);
        add_fields(OP_TOWER, 22, 0, 0, 0, 500000, 0, -150000, 0);
        add_fields(OP_JET, 4600, 1300, 0, PHI_SPAN, 0, 0, 0, 0);   // late jet near +pi
        add_fields(OP_TOWER, 23, 0, 0, 0, 0, 0, -262144, 0);
        add_fields(OP_END, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Random phases: window setting and idle pattern per phase
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            lo_a = rand_low();
            lo_b = rand_low();
            case (ph)
                0: set_windows(18'd0, 18'h3FFFF, 18'd0, 18'h3FFFF);          // wide open
                1: set_windows(lo_a, CFG_W'(lo_a + $urandom_range(60000, 0)),
                               lo_b, CFG_W'(lo_b + $urandom_range(60000, 0)));
                2: set_windows(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);  // top only
                3: set_windows(18'd5000, 18'd4000, 18'd1520, 18'd1040);      // inverted
                4: set_windows(18'd3200, 18'd4800, 18'd1040, 18'd1520);
                5: set_windows(lo_a, CFG_W'(lo_a + $urandom_range(5000, 0)),
                               lo_b, CFG_W'(lo_b + $urandom_range(5000, 0)));
                6: set_windows(18'd0, 18'd0, 18'd0, 18'd0);                  // zero pt only
                default: set_windows(lo_a, 18'h3FFFF, 18'd0, lo_b);
            endcase
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 64; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 64; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            start = items_queued;
            while (items_queued - start < PHASE_ITEMS) begin
                if ($urandom_range(9, 0) == 0)
                    add_item(random_item(op_t'($urandom_range(3, 0))));
                else
                    queue_event();
            end
            drain();
        end

        $display("Run covered %0d input transfers: %0d tower transfers,",
                 items_taken, towers_seen);
        $display("%0d summaries (%0d with a jet); windows reset, wide open, top-only,",
                 summaries_seen, summaries_with_jet);
        $display("inverted, zero and random under four idle patterns.");
        if (err_count == 0) begin
            $display("leading_jet_tower_window_filter_tb OK");
        end else begin
            $display("leading_jet_tower_window_filter_tb NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(2_000_000);
        $display("Timeout after %0d of %0d items", items_taken, items_queued);
        $display("leading_jet_tower_window_filter_tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ljtw_pkg.sv
hw/rtl/ljtw_front.sv
hw/rtl/ljtw_queue.sv
hw/rtl/ljtw_back.sv
hw/rtl/leading_jet_tower_window_filter.sv
hw/rtl/ljtw_checker.sv
verif/leading_jet_tower_window_filter_tb.sv
